>>> hw/rtl/rcmix_pkg.sv
// Shared types, register indexes and channel helpers for the RC mixer / H-bridge drive.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcmix_pkg;

    localparam int DUTY_MAX = 1000;
    localparam logic [9:0] DUTY_MAX_W = 10'(DUTY_MAX);

    localparam logic [11:0] THR_MIN_US = 12'd1000;
    localparam logic [9:0]  CHAN_FULL  = 10'd1000;
    localparam logic [9:0]  CHAN_CTR   = 10'd500;

    localparam logic [2:0] REG_TRIM_PITCH    = 3'd0;
    localparam logic [2:0] REG_TRIM_THROTTLE = 3'd1;
    localparam logic [2:0] REG_TRIM_YAW      = 3'd2;
    localparam logic [2:0] REG_YAW_GAIN      = 3'd3;
    localparam logic [2:0] REG_PITCH_GAIN    = 3'd4;
    localparam logic [2:0] REG_DEAD_BAND     = 3'd5;

    localparam logic [1:0] PINS_OFF = 2'b11;
    localparam logic [1:0] PINS_FWD = 2'b01;
    localparam logic [1:0] PINS_REV = 2'b10;

    typedef struct packed {
        logic signed [10:0] trim_pitch;
        logic signed [10:0] trim_throttle;
        logic signed [10:0] trim_yaw;
        logic [9:0]         yaw_gain;
        logic [9:0]         pitch_gain;
        logic [8:0]         dead_band;
    } cfg_t;

    typedef struct packed {
        logic       armed;
        logic       rev_pos;
        logic [1:0] pins;
    } state_t;

    typedef struct packed {
        logic [9:0] left_duty;
        logic [9:0] right_duty;
        logic [9:0] fwd_duty;
        logic [9:0] rev_duty;
        logic       pin_a_level;
        logic       pin_b_level;
        logic       settle_request;
        logic       status;
    } res_t;

    // pulse - 1000 + trim, clamped to 0..1000
    function automatic logic [9:0] chan_clamp(input logic [11:0] pulse,
                                              input logic signed [10:0] trim);
        logic signed [13:0] v;
        v = $signed({2'b00, pulse}) - $signed({4'b0000, CHAN_FULL})
            + $signed({{3{trim[10]}}, trim});
        if (v < 14'sd0)
            chan_clamp = 10'd0;
        else if (v > $signed({4'b0000, CHAN_FULL}))
            chan_clamp = CHAN_FULL;
        else
            chan_clamp = v[9:0];
    endfunction

    function automatic logic [9:0] sat_duty(input logic signed [12:0] v);
        if (v < 13'sd0)
            sat_duty = 10'd0;
        else if (v > $signed({3'b000, DUTY_MAX_W}))
            sat_duty = DUTY_MAX_W;
        else
            sat_duty = v[9:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rcmix_cfg.sv
// Configuration register file: six trim/gain/deadband registers on a plain write port.
// Depends on rcmix_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcmix_cfg
    import rcmix_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRIM_PITCH:    cfg_next.trim_pitch    = $signed(cfg_data);
                REG_TRIM_THROTTLE: cfg_next.trim_throttle = $signed(cfg_data);
                REG_TRIM_YAW:      cfg_next.trim_yaw      = $signed(cfg_data);
                REG_YAW_GAIN:      cfg_next.yaw_gain      = cfg_data[9:0];
                REG_PITCH_GAIN:    cfg_next.pitch_gain    = cfg_data[9:0];
                REG_DEAD_BAND:     cfg_next.dead_band     = cfg_data[8:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trim_pitch    <= 11'sd0;
            cfg_reg.trim_throttle <= -11'sd100;
            cfg_reg.trim_yaw      <= 11'sd0;
            cfg_reg.yaw_gain      <= 10'd102;
            cfg_reg.pitch_gain    <= 10'd256;
            cfg_reg.dead_band     <= 9'd70;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rcmix_core.sv
// Combinational mix: channel trim/clamp, yaw differential, arm latch, bridge direction
// and deadband. Produces one result beat and the next drive state. Depends on rcmix_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcmix_core
    import rcmix_pkg::*;
(
    input  wire cfg_t         cfg,
    input  wire state_t       state,
    input  wire logic [11:0]  pitch_pulse,
    input  wire logic [11:0]  throttle_pulse,
    input  wire logic [11:0]  yaw_pulse,
    output res_t              res,
    output state_t            state_next
);

    logic               cut;
    logic [9:0]         pit;
    logic [9:0]         thr;
    logic [9:0]         yaw;
    logic signed [10:0] d;
    logic [8:0]         dm;
    logic [18:0]        yprod;
    logic [10:0]        ymag;
    logic signed [12:0] yterm;
    logic signed [12:0] thr_s;
    logic signed [12:0] left;
    logic signed [12:0] right;
    logic               thr_zero;
    logic               armed_new;
    logic [9:0]         pit_eff;
    logic signed [10:0] p;
    logic [8:0]         mag;
    logic               p_pos;
    logic               in_band;
    logic [19:0]        dprod;
    logic [11:0]        drive_raw;
    logic [9:0]         drive;
    logic [1:0]         pins_new;

    always_comb
    begin
        cut = throttle_pulse < THR_MIN_US;

        pit = chan_clamp(pitch_pulse, cfg.trim_pitch);
        thr = chan_clamp(throttle_pulse, cfg.trim_throttle);
        yaw = chan_clamp(yaw_pulse, cfg.trim_yaw);

        // yaw differential, magnitude truncated toward zero
        d     = $signed({1'b0, yaw}) - $signed({1'b0, CHAN_CTR});
        dm    = d[10] ? 9'(-d) : d[8:0];
        yprod = {10'd0, dm} * {9'd0, cfg.yaw_gain};
        ymag  = yprod[18:8];
        yterm = d[10] ? -$signed({2'b00, ymag}) : $signed({2'b00, ymag});
        thr_s = $signed({3'b000, thr});
        left  = thr_s - yterm;
        right = thr_s + yterm;

        thr_zero  = (thr == 10'd0);
        armed_new = state.armed | thr_zero;
        if (!armed_new || thr_zero)
        begin
            left  = 13'sd0;
            right = 13'sd0;
        end
        pit_eff = armed_new ? pit : CHAN_CTR;

        // bridge
        p       = $signed({1'b0, pit_eff}) - $signed({1'b0, CHAN_CTR});
        p_pos   = !p[10] && (p != 11'sd0);
        mag     = p[10] ? 9'(-p) : p[8:0];
        in_band = (p == 11'sd0) || (mag < cfg.dead_band);
        dprod     = {1'b0, mag} * {10'd0, cfg.pitch_gain} * 20'd2;
        drive_raw = dprod[19:8];
        drive     = (drive_raw > {2'b00, DUTY_MAX_W}) ? DUTY_MAX_W : drive_raw[9:0];

        if (in_band)
            pins_new = PINS_OFF;
        else if (p_pos)
            pins_new = PINS_FWD;
        else
            pins_new = PINS_REV;

        if (cut)
        begin
            res.left_duty      = 10'd0;
            res.right_duty     = 10'd0;
            res.fwd_duty       = 10'd0;
            res.rev_duty       = 10'd0;
            res.pin_a_level    = state.pins[0];
            res.pin_b_level    = state.pins[1];
            res.settle_request = 1'b0;
            res.status         = 1'b1;
            state_next         = state;
        end
        else
        begin
            res.left_duty      = sat_duty(left);
            res.right_duty     = sat_duty(right);
            res.fwd_duty       = (!in_band && p_pos) ? drive : 10'd0;
            res.rev_duty       = (!in_band && !p_pos) ? drive : 10'd0;
            res.pin_a_level    = pins_new[0];
            res.pin_b_level    = pins_new[1];
            res.settle_request = (state.rev_pos != p_pos);
            res.status         = 1'b0;
            state_next.armed   = armed_new;
            state_next.rev_pos = p_pos;
            state_next.pins    = pins_new;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rc_mixer_hbridge_drive.sv
// RC mixer and H-bridge drive, top level: input register, mix logic, result register.
// Depends on rcmix_pkg, rcmix_cfg and rcmix_core.
//
// One RC frame (pitch, throttle, yaw pulse widths in us) per beat maps to four PWM compare
// values, two bridge switch levels, a settle request and a status bit. An input beat is
// taken every cycle while in_stall is low; it is captured in the input register, which
// feeds the mix logic; the result register loads unless out_stall holds a valid result.
// The arm latch, direction latch and bridge pins update when a frame moves into the
// result register, so frames are mixed in arrival order. The configuration registers
// come out of reset at their defaults; the user must see that they are written only
// while no frame is in flight, which the block itself does not enforce. in_stall rises
// only when both registers are full and out_stall holds the result.
`timescale 1ns / 1ps
`default_nettype none

module rc_mixer_hbridge_drive
    import rcmix_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [11:0] pitch_pulse,
    input  wire logic [11:0] throttle_pulse,
    input  wire logic [11:0] yaw_pulse,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [9:0]       left_duty,
    output logic [9:0]       right_duty,
    output logic [9:0]       fwd_duty,
    output logic [9:0]       rev_duty,
    output logic             pin_a_level,
    output logic             pin_b_level,
    output logic             settle_request,
    output logic             status
);

    cfg_t        cfg;
    state_t      state_reg;
    state_t      state_next;
    res_t        res_next;
    res_t        res_reg;
    logic        in_valid_reg;
    logic [11:0] pitch_reg;
    logic [11:0] throttle_reg;
    logic [11:0] yaw_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        in_take;

    rcmix_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcmix_core u_core
    (
        .cfg            (cfg),
        .state          (state_reg),
        .pitch_pulse    (pitch_reg),
        .throttle_pulse (throttle_reg),
        .yaw_pulse      (yaw_reg),
        .res            (res_next),
        .state_next     (state_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.armed   <= 1'b0;
            state_reg.rev_pos <= 1'b0;
            state_reg.pins    <= PINS_OFF;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pitch_reg    <= pitch_pulse;
            throttle_reg <= throttle_pulse;
            yaw_reg      <= yaw_pulse;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid      = out_valid_reg;
    assign left_duty      = res_reg.left_duty;
    assign right_duty     = res_reg.right_duty;
    assign fwd_duty       = res_reg.fwd_duty;
    assign rev_duty       = res_reg.rev_duty;
    assign pin_a_level    = res_reg.pin_a_level;
    assign pin_b_level    = res_reg.pin_b_level;
    assign settle_request = res_reg.settle_request;
    assign status         = res_reg.status;

    a_cut_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.status |->
            res_reg.left_duty == 10'd0 && res_reg.right_duty == 10'd0 &&
            res_reg.fwd_duty == 10'd0 && res_reg.rev_duty == 10'd0 &&
            !res_reg.settle_request)
        else $error("cut frame with nonzero drive");

    a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.pin_a_level || res_reg.pin_b_level)
        else $error("both bridge switches on");

    a_fwd_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.fwd_duty != 10'd0 |->
            res_reg.pin_a_level && !res_reg.pin_b_level && res_reg.rev_duty == 10'd0)
        else $error("forward duty with wrong pins");

    a_rev_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.rev_duty != 10'd0 |->
            !res_reg.pin_a_level && res_reg.pin_b_level)
        else $error("reverse duty with wrong pins");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> state_reg == $past(state_reg))
        else $error("drive state changed without a frame");

endmodule

`default_nettype wire
